// File: hw/rtl/line_angle_from_endpoints_defines.svh
// ----------------------------------------------------------------------------
// line_angle_from_endpoints_defines
// assertion macros shared by the line angle rtl, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LINE_ANGLE_FROM_ENDPOINTS_DEFINES_SVH
`define LINE_ANGLE_FROM_ENDPOINTS_DEFINES_SVH

// same-cycle implication
`define LAFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LAFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lafe_pkg.sv
// ----------------------------------------------------------------------------
// lafe_pkg
// widths, angle table, shared types and the micro-rotation function of the
// line angle pipeline
// ----------------------------------------------------------------------------
package lafe_pkg;

	// field widths
	localparam int COORD_BITS = 16;
	localparam int ANGLE_BITS = 16;

	// rotation engine sizing
	localparam int STEPS    = 31;
	localparam int STEP_IW  = $clog2(STEPS);
	localparam int Z_FRAC   = 31;
	localparam int XW       = 64;
	localparam int ZW       = Z_FRAC + 2;
	localparam int DW       = COORD_BITS + 1;
	localparam int SCALE_SH = 60 - COORD_BITS;

	// pi/2 in angle accumulator units
	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(1) << (Z_FRAC - 1);

	// atan(2^-i) in units of pi / 2^31
	localparam logic [Z_FRAC-1:0] ATAN_TAB [STEPS] = '{
		31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
		31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
		31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
		31'd166886,    31'd83443,     31'd41722,     31'd20861,
		31'd10430,     31'd5215,      31'd2608,      31'd1304,
		31'd652,       31'd326,       31'd163,       31'd81,
		31'd41,        31'd20,        31'd10,        31'd5,
		31'd3,         31'd1,         31'd1
	};

	// how the angle of a word is found
	typedef enum logic [1:0] {
		KIND_ROT,
		KIND_VERT,
		KIND_HORIZ
	} kind_t;

	// control that travels with each word
	typedef struct packed {
		logic  valid;
		kind_t kind;
	} tag_t;

	// rotation vector and angle accumulator
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	// one vectoring micro-rotation, driving y toward zero
	function automatic vec_t cordic_step(input vec_t v, input int i);
		vec_t                 r;
		logic signed [XW-1:0] xv;
		logic signed [XW-1:0] yv;
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		logic signed [ZW-1:0] t;
		logic [STEP_IW-1:0]   idx;
		idx = STEP_IW'(i);
		xv  = v.x;
		yv  = v.y;
		xs  = xv >>> i;
		ys  = yv >>> i;
		t   = {{(ZW - Z_FRAC){1'b0}}, ATAN_TAB[idx]};
		if (!yv[XW-1]) begin
			r.x = xv + ys;
			r.y = yv - xs;
			r.z = v.z + t;
		end else begin
			r.x = xv - ys;
			r.y = yv + xs;
			r.z = v.z - t;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/lafe_prep.sv
// ----------------------------------------------------------------------------
// lafe_prep
// first two pipeline stages: endpoint differences, special-case detection,
// canonical ordering, quadrant pre-rotation and fixed-point scaling
// ----------------------------------------------------------------------------
`include "line_angle_from_endpoints_defines.svh"

module lafe_prep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                word_valid,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] end_y,
	output lafe_pkg::tag_t                      start_tag,
	output lafe_pkg::vec_t                      start_vec
);
	import lafe_pkg::*;

	logic                 valid_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;

	tag_t tag_s2;
	vec_t vec_s2;

	logic                 dy_neg;
	logic signed [DW-1:0] ax;
	logic signed [DW-1:0] ay;
	logic signed [DW-1:0] xi;
	logic signed [DW-1:0] yi;
	tag_t                 tag_nxt;
	vec_t                 vec_nxt;

	logic                 rot_word_s2;
	logic                 start_first_quad;

	// stage 1: exact differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
			dy_s1 <= {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
		end
	end

	// swap endpoints so dy is positive, then fold the left half-plane
	always_comb begin
		dy_neg = dy_s1[DW-1];
		ax     = dy_neg ? -dx_s1 : dx_s1;
		ay     = dy_neg ? -dy_s1 : dy_s1;
		if (ax[DW-1]) begin
			xi        = ay;
			yi        = -ax;
			vec_nxt.z = Z_QUARTER;
		end else begin
			xi        = ax;
			yi        = ay;
			vec_nxt.z = '0;
		end
		vec_nxt.x = {{(XW - DW){xi[DW-1]}}, xi} << SCALE_SH;
		vec_nxt.y = {{(XW - DW){yi[DW-1]}}, yi} << SCALE_SH;

		tag_nxt.valid = valid_s1;
		if (dx_s1 == '0) begin
			tag_nxt.kind = KIND_VERT;
		end else if (dy_s1 == '0) begin
			tag_nxt.kind = KIND_HORIZ;
		end else begin
			tag_nxt.kind = KIND_ROT;
		end
	end

	// stage 2: rotation start vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s2 <= vec_nxt;
		end
	end

	assign start_tag = tag_s2;
	assign start_vec = vec_s2;

	// a word entering the rotations starts in the right half-plane, above the axis
	assign rot_word_s2      = tag_s2.valid && tag_s2.kind == KIND_ROT;
	assign start_first_quad = !vec_s2.x[XW-1] && !vec_s2.y[XW-1];

	`LAFE_ASSERT_IMP(a_start_quadrant, rot_word_s2, start_first_quad, "start vector off quadrant")

endmodule

// File: hw/rtl/lafe_cordic.sv
// ----------------------------------------------------------------------------
// lafe_cordic
// unrolled vectoring rotation pipeline, one micro-rotation per stage
// ----------------------------------------------------------------------------
module lafe_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  lafe_pkg::tag_t                     head_tag,
	input  lafe_pkg::vec_t                     head_vec,
	output lafe_pkg::tag_t                     tail_tag,
	output logic signed [lafe_pkg::ZW-1:0]     tail_z
);
	import lafe_pkg::*;

	tag_t tag_s [STEPS];
	vec_t vec_s [STEPS];

	// rotation stages
	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		tag_t tag_in;
		vec_t vec_in;

		if (k == 0) begin : g_head
			assign tag_in = head_tag;
			assign vec_in = head_vec;
		end else begin : g_body
			assign tag_in = tag_s[k-1];
			assign vec_in = vec_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (adv) begin
				tag_s[k] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				vec_s[k] <= cordic_step(vec_in, k);
			end
		end
	end

	assign tail_tag = tag_s[STEPS-1];
	assign tail_z   = vec_s[STEPS-1].z;

endmodule

// File: hw/rtl/lafe_out.sv
// ----------------------------------------------------------------------------
// lafe_out
// angle clamp and rounding, output register and one-word skid buffer
// ----------------------------------------------------------------------------
`include "line_angle_from_endpoints_defines.svh"

module lafe_out (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lafe_pkg::tag_t                       tail_tag,
	input  logic signed [lafe_pkg::ZW-1:0]       tail_z,
	output logic                                 adv,
	output logic                                 angle_valid,
	input  logic                                 angle_stall,
	output logic [lafe_pkg::ANGLE_BITS-1:0]      line_angle
);
	import lafe_pkg::*;

	logic [Z_FRAC-1:0]     zc;
	logic [ANGLE_BITS-1:0] rnd;
	logic [ANGLE_BITS-1:0] res;

	logic                  out_v_q;
	logic [ANGLE_BITS-1:0] out_d_q;
	logic                  sk_v_q;
	logic [ANGLE_BITS-1:0] sk_d_q;

	logic                  out_held;

	// clamp accumulator to [0, 2^31 - 1]
	always_comb begin
		if (tail_z[ZW-1]) begin
			zc = '0;
		end else if (|tail_z[ZW-2:Z_FRAC]) begin
			zc = '1;
		end else begin
			zc = tail_z[Z_FRAC-1:0];
		end
	end

	// scale to the output width, round half up, saturate below pi
	if (ANGLE_BITS > Z_FRAC) begin : g_widen
		assign rnd = {zc, {(ANGLE_BITS - Z_FRAC){1'b0}}};
	end else if (ANGLE_BITS == Z_FRAC) begin : g_same
		assign rnd = zc;
	end else begin : g_narrow
		localparam int SH = Z_FRAC - ANGLE_BITS;
		logic [Z_FRAC:0]       sum;
		logic [ANGLE_BITS:0]   top;
		assign sum = {1'b0, zc} + ((Z_FRAC + 1)'(1) << (SH - 1));
		assign top = sum[Z_FRAC:SH];
		assign rnd = top[ANGLE_BITS] ? '1 : top[ANGLE_BITS-1:0];
	end

	always_comb begin
		case (tail_tag.kind)
			KIND_VERT:  res = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
			KIND_HORIZ: res = '0;
			KIND_ROT:   res = rnd;
			default:    res = rnd;
		endcase
	end

	// pipeline moves whenever the skid stage is empty
	assign adv = !sk_v_q;

	// output and skid valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (!angle_stall) begin
				sk_v_q <= 1'b0;
			end
		end else if (!out_v_q || !angle_stall) begin
			out_v_q <= tail_tag.valid;
		end else if (tail_tag.valid) begin
			sk_v_q <= 1'b1;
		end
	end

	// output and skid words
	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (!angle_stall) begin
				out_d_q <= sk_d_q;
			end
		end else if (!out_v_q || !angle_stall) begin
			out_d_q <= res;
		end else begin
			sk_d_q <= res;
		end
	end

	assign angle_valid = out_v_q;
	assign line_angle  = out_d_q;

	// output word waiting on the receiver
	assign out_held = out_v_q && angle_stall;

	`LAFE_ASSERT_IMP(a_skid_needs_out, sk_v_q, out_v_q, "skid full with output empty")
	`LAFE_ASSERT_NXT(a_skid_catch, adv && tail_tag.valid && out_held, sk_v_q, "tail word lost")
	`LAFE_ASSERT_NXT(a_skid_drain, sk_v_q && !angle_stall, !sk_v_q && out_v_q, "skid word stuck")

endmodule

// File: hw/rtl/line_angle_from_endpoints.sv
// ----------------------------------------------------------------------------
// line_angle_from_endpoints
// undirected line angle in [0, pi) from two segment endpoints
// ----------------------------------------------------------------------------
// Takes one endpoint pair per cycle while coord_stall is low and returns one
// angle word per pair, in order, in units of pi/65536 (32768 is a vertical
// line, equal x coordinates and coincident points included; equal y gives 0).
// An accepted coordinate word passes two preparation stages, 31 stages of
// the unrolled vectoring rotator (one micro-rotation and one 64-bit add pair
// per stage) and the rounding/output register. Sustained rate is one word per
// cycle while the output is not stalled. A one-word skid buffer sits behind
// the output register; coord_stall rises in the cycle after the output has
// been stalled with a word waiting behind it, and comes straight from a flop.
module line_angle_from_endpoints (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   coord_valid,
	output logic                                   coord_stall,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [lafe_pkg::COORD_BITS-1:0] end_y,
	output logic                                   angle_valid,
	input  logic                                   angle_stall,
	output logic [lafe_pkg::ANGLE_BITS-1:0]        line_angle
);
	import lafe_pkg::*;

	logic                 adv;
	tag_t                 prep_tag;
	vec_t                 prep_vec;
	tag_t                 rot_tag;
	logic signed [ZW-1:0] rot_z;

	// input side stalls only while the skid stage is full
	assign coord_stall = !adv;

	// differences, ordering and pre-rotation
	lafe_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.word_valid (coord_valid),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.start_tag  (prep_tag),
		.start_vec  (prep_vec)
	);

	// micro-rotation pipeline
	lafe_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.head_tag (prep_tag),
		.head_vec (prep_vec),
		.tail_tag (rot_tag),
		.tail_z   (rot_z)
	);

	// rounding and output buffering
	lafe_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.tail_tag    (rot_tag),
		.tail_z      (rot_z),
		.adv         (adv),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.line_angle  (line_angle)
	);

endmodule

// File: dv/tb_line_angle_from_endpoints.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_angle_from_endpoints
// self-checking bench for the segment line angle pipeline
// ----------------------------------------------------------------------------
// Drives endpoint pairs through the coordinate channel and checks every
// angle word against a bit-exact vectoring rotator model kept in the bench.
// Directed segments hit vertical, horizontal, coincident, diagonal, swapped
// and saturating cases; random segments follow under three idle mixes on the
// two channels, with full drains between the mixes.
// ----------------------------------------------------------------------------
module tb_line_angle_from_endpoints;

	localparam int CB        = lafe_pkg::COORD_BITS;
	localparam int AB        = lafe_pkg::ANGLE_BITS;
	localparam int ROTATIONS = 31;
	localparam int ACC_FRAC  = 31;
	localparam int SCALE_SH  = 60 - CB;
	localparam int ROUND_SH  = ACC_FRAC - AB;
	localparam int TAIL      = 40;
	localparam int LIMIT     = 400000;

	// atan(2^-i) in units of pi / 2^31
	localparam longint ATAN_STEP [ROTATIONS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1
	};

	typedef enum {
		SHAPE_VERTICAL,
		SHAPE_HORIZONTAL,
		SHAPE_POINT,
		SHAPE_SHORT,
		SHAPE_ANY
	} seg_shape_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 coord_valid = 1'b0;
	logic                 coord_stall;
	logic signed [CB-1:0] start_x     = '0;
	logic signed [CB-1:0] start_y     = '0;
	logic signed [CB-1:0] end_x       = '0;
	logic signed [CB-1:0] end_y       = '0;
	logic                 angle_valid;
	logic                 angle_stall = 1'b0;
	logic [AB-1:0]        line_angle;

	logic [AB-1:0] expected_angles [$];
	logic [AB-1:0] oldest_angle;
	int unsigned   send_idle_pct   = 0;
	int unsigned   recv_idle_pct   = 0;
	int unsigned   words_sent      = 0;
	int unsigned   words_checked   = 0;
	int unsigned   fail_count      = 0;
	int unsigned   cycle_count     = 0;

	line_angle_from_endpoints u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.coord_valid (coord_valid),
		.coord_stall (coord_stall),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.line_angle  (line_angle)
	);

	// clock
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// undirected segment angle through the vectoring rotator
	function automatic logic [AB-1:0] line_angle_of(
		input logic signed [CB-1:0] sx,
		input logic signed [CB-1:0] sy,
		input logic signed [CB-1:0] ex,
		input logic signed [CB-1:0] ey
	);
		longint dx;
		longint dy;
		longint x;
		longint y;
		longint xs;
		longint ys;
		longint z;
		longint r;
		dx = longint'(ex) - longint'(sx);
		dy = longint'(ey) - longint'(sy);
		if (dx == 0)
			return AB'(1) << (AB - 1);
		if (dy == 0)
			return '0;
		// canonical order puts the y difference positive
		if (dy < 0) begin
			dx = -dx;
			dy = -dy;
		end
		// left half plane starts from a quarter turn
		if (dx < 0) begin
			x = dy;
			y = -dx;
			z = longint'(1) << (ACC_FRAC - 1);
		end else begin
			x = dx;
			y = dy;
			z = 0;
		end
		x = x <<< SCALE_SH;
		y = y <<< SCALE_SH;
		for (int i = 0; i < ROTATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_STEP[i];
			end
		end
		// clamp, round half up, saturate below pi
		if (z < 0)
			z = 0;
		if (z > (longint'(1) << ACC_FRAC) - 1)
			z = (longint'(1) << ACC_FRAC) - 1;
		r = (z + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
		if (r > (longint'(1) << AB) - 1)
			r = (longint'(1) << AB) - 1;
		return AB'(r);
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		angle_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// angle word checker
	always @(posedge clk) begin
		if (arst_n && angle_valid && !angle_stall) begin
			if (expected_angles.size() == 0) begin
				$error("line_angle expected none actual %0d", line_angle);
				fail_count++;
			end else begin
				oldest_angle = expected_angles.pop_front();
				words_checked++;
				if (line_angle !== oldest_angle) begin
					$error("line_angle expected %0d actual %0d", oldest_angle, line_angle);
					fail_count++;
				end
			end
		end
	end

	// send one coordinate word, with a random gap ahead of it
	task automatic send_segment(
		input logic signed [CB-1:0] sx,
		input logic signed [CB-1:0] sy,
		input logic signed [CB-1:0] ex,
		input logic signed [CB-1:0] ey
	);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			coord_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coord_valid <= 1'b1;
		start_x     <= sx;
		start_y     <= sy;
		end_x       <= ex;
		end_y       <= ey;
		do
			@(posedge clk);
		while (coord_stall);
		expected_angles = {expected_angles, line_angle_of(sx, sy, ex, ey)};
		words_sent++;
	endtask

	// hold off the sender until every angle word is back
	task automatic drain_angles();
		coord_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_angles.size() != 0);
	endtask

	// equal x, coincident points included
	task automatic test_vertical_lines();
		send_segment(16'sd0, 16'sd0, 16'sd0, 16'sd100);
		send_segment(16'sd5, -16'sd7, 16'sd5, -16'sd7);
		send_segment(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767);
		send_segment(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768);
	endtask

	// equal y with distinct x
	task automatic test_horizontal_lines();
		send_segment(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
		send_segment(16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768);
		send_segment(16'sd1, 16'sd5, 16'sd2, 16'sd5);
	endtask

	// both quadrants and the endpoint swap
	task automatic test_diagonals_and_swap();
		send_segment(16'sd0, 16'sd0, 16'sd100, 16'sd100);
		send_segment(16'sd0, 16'sd0, -16'sd100, 16'sd100);
		send_segment(16'sd100, 16'sd100, 16'sd0, 16'sd0);
		send_segment(16'sd0, 16'sd100, 16'sd100, 16'sd0);
		send_segment(16'sd0, 16'sd0, 16'sd1, 16'sd1);
		send_segment(16'sd0, 16'sd1, 16'sd1, 16'sd0);
	endtask

	// full-range differences, near-pi saturation and near-zero angles
	task automatic test_range_extremes();
		send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
		send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
		send_segment(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
		send_segment(16'sd32767, 16'sd0, -16'sd32768, 16'sd1);
		send_segment(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1);
		send_segment(16'sd0, -16'sd32768, 16'sd1, 16'sd32767);
		send_segment(16'sd1, -16'sd32768, 16'sd0, 16'sd32767);
		send_segment(16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845);
		send_segment(16'sd32767, 16'sd0, -16'sd32768, -16'sd1);
	endtask

	// random segments, half general, the rest degenerate or short
	task automatic test_random_segments(input int unsigned count);
		logic signed [CB-1:0] sx;
		logic signed [CB-1:0] sy;
		logic signed [CB-1:0] ex;
		logic signed [CB-1:0] ey;
		int unsigned          pick;
		seg_shape_t           shape;
		for (int unsigned n = 0; n < count; n++) begin
			sx   = CB'($urandom);
			sy   = CB'($urandom);
			ex   = CB'($urandom);
			ey   = CB'($urandom);
			pick = $urandom_range(9);
			case (pick)
				0:       shape = SHAPE_VERTICAL;
				1:       shape = SHAPE_HORIZONTAL;
				2:       shape = SHAPE_POINT;
				3, 4:    shape = SHAPE_SHORT;
				default: shape = SHAPE_ANY;
			endcase
			case (shape)
				SHAPE_VERTICAL:   ex = sx;
				SHAPE_HORIZONTAL: ey = sy;
				SHAPE_POINT: begin
					ex = sx;
					ey = sy;
				end
				SHAPE_SHORT: begin
					ex = CB'(int'(sx) + int'($urandom_range(16)) - 8);
					ey = CB'(int'(sy) + int'($urandom_range(16)) - 8);
				end
				default: ;
			endcase
			send_segment(sx, sy, ex, ey);
		end
	endtask

	// test sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver mostly stalled
		send_idle_pct = 21;
		recv_idle_pct = 77;
		test_vertical_lines();
		test_horizontal_lines();
		test_diagonals_and_swap();
		test_range_extremes();
		test_random_segments(620);
		drain_angles();

		// sender mostly idle, receiver mostly ready
		send_idle_pct = 77;
		recv_idle_pct = 21;
		test_random_segments(615);
		drain_angles();

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_segments(615);
		drain_angles();
		repeat (TAIL) @(posedge clk);

		$display("sent %0d coordinate words under three idle mixes, %0d angle words checked",
			words_sent, words_checked);
		$display("directed vertical, horizontal, swapped and saturating segments included");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lafe_pkg.sv
hw/rtl/lafe_prep.sv
hw/rtl/lafe_cordic.sv
hw/rtl/lafe_out.sv
hw/rtl/line_angle_from_endpoints.sv
dv/tb_line_angle_from_endpoints.sv
